FILE: rtl/core/spq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types, codes and the scoring function of the scored priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    // Operation codes carried in the operation field of an input word.
    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_SERVE = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // Job letters as ASCII bytes.
    localparam logic [7:0] JOB_M = 8'h4D;
    localparam logic [7:0] JOB_S = 8'h53;
    localparam logic [7:0] JOB_O = 8'h4F;

    // Age thresholds in years.
    localparam logic [7:0] AGE_SENIOR = 8'd60;
    localparam logic [7:0] AGE_MIDDLE = 8'd40;
    localparam logic [7:0] AGE_ADULT  = 8'd20;

    // One slot of the sign-up store.
    typedef struct packed {
        logic        waiting;
        logic [2:0]  score;
        logic [15:0] id;
    } t_entry;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;     // capture the accepted input word
        logic set_empty;   // mark the result as a serve on an empty queue
        logic do_add;      // sign up the captured person (or flag a full store)
        logic do_clr;      // retire the current head and start a rescan
        logic scan_step;   // advance the head search by one slot
        logic scan_finish; // copy the search winner into the head registers
        logic load_out;    // move the finished result into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic op_serve;    // the captured word is a serve
        logic head_valid;  // someone is waiting
        logic scan_done;   // every used slot has been compared
        logic out_busy;    // the output register still holds an untaken result
    } t_sts;

    // Job score plus age score.
    function automatic logic [2:0] score_of(input logic [7:0] job, input logic [7:0] age);
        logic [2:0] job_pts;
        logic [2:0] age_pts;
        priority if (job == JOB_M) job_pts = 3'd3;
        else if (job == JOB_S)     job_pts = 3'd2;
        else if (job == JOB_O)     job_pts = 3'd1;
        else                       job_pts = 3'd0;
        priority if (age >= AGE_SENIOR) age_pts = 3'd4;
        else if (age >= AGE_MIDDLE)     age_pts = 3'd3;
        else if (age >= AGE_ADULT)      age_pts = 3'd2;
        else                            age_pts = 3'd1;
        return job_pts + age_pts;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/scored_priority_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scored_priority_queue
// Stable priority queue that scores each person it signs up and serves the
// highest score first, earliest sign-up first among equal scores.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+----------------------------
//   input   | in        | i_in_valid / o_in_ready | operation, person_id,
//           |           |                         | job_code, age_years
//   result  | out       | o_out_valid/i_out_ready | status, served_id,
//           |           |                         | head_valid, head_id,
//           |           |                         | head_priority, waiting_count
//
// An add word passes from the decide state through the add state to the done
// state, which moves its result into the output register once that is free.
// A serve word with someone waiting retires the head in the decide state and
// then finds the new head in the scan state, reading every used slot of the
// sign-up store one slot per cycle through its single read port into one
// score comparator. A serve on an empty queue goes from the decide state
// straight to the done state. Reset is synchronous and active low and needs
// no clearing pass: slots beyond the sign-up count are never read. One word
// is in flight at a time; a result that is not taken holds in the output
// register and the next word is accepted once it has been handed over there.
//
module scored_priority_queue
    import spq_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_operation,
    input  wire logic [15:0] i_person_id,
    input  wire logic [7:0]  i_job_code,
    input  wire logic [7:0]  i_age_years,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_status,
    output logic [15:0]      o_served_id,
    output logic             o_head_valid,
    output logic [15:0]      o_head_id,
    output logic [2:0]       o_head_priority,
    output logic [6:0]       o_waiting_count
);

    // Command and status bundles between the sequencer and the datapath.
    t_cmd cmd;
    t_sts sts;

    // The sequencer owns the input handshake and decides every step.
    spq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // The datapath holds the store, the head, the search and the result.
    spq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_operation     (i_operation),
        .i_person_id     (i_person_id),
        .i_job_code      (i_job_code),
        .i_age_years     (i_age_years),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_status        (o_status),
        .o_served_id     (o_served_id),
        .o_head_valid    (o_head_valid),
        .o_head_id       (o_head_id),
        .o_head_priority (o_head_priority),
        .o_waiting_count (o_waiting_count)
    );

    // Only one word is worked on at a time: after an accept, ready drops.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted while a word is still in flight");

    // A rejected word never reports a served id.
    a_reject_no_serve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_OK)) |-> (o_served_id == 16'd0))
        else $error("rejected word reports a served id");

    // A serve on an empty queue leaves nobody at the head.
    a_empty_no_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_EMPTY)) |-> (!o_head_valid && o_head_id == 16'd0))
        else $error("empty serve reports a head");

    // The result register is loaded only when it is free.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> (!o_out_valid || i_out_ready))
        else $error("untaken result overwritten");

endmodule
`default_nettype wire

FILE: rtl/core/spq_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spq_ctrl
// Sequencer of the queue: takes one word, steps the datapath through an add
// or a serve with its head rescan, and hands the result to the output stage.
// ----------------------------------------------------------------------------
module spq_ctrl
    import spq_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECIDE = 5'b00010,
        S_ADD    = 5'b00100,
        S_SCAN   = 5'b01000,
        S_DONE   = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_DECIDE;
                end
            end
            S_DECIDE: begin
                priority if (!i_sts.op_serve) begin
                    n_state = S_ADD;
                end else if (i_sts.head_valid) begin
                    o_cmd.do_clr = 1'b1;
                    n_state      = S_SCAN;
                end else begin
                    o_cmd.set_empty = 1'b1;
                    n_state         = S_DONE;
                end
            end
            S_ADD: begin
                o_cmd.do_add = 1'b1;
                n_state      = S_DONE;
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    o_cmd.scan_finish = 1'b1;
                    n_state           = S_DONE;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule
`default_nettype wire

FILE: rtl/core/spq_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spq_datapath
// Sign-up store, counters, head registers, the one-comparator head search
// and the output register of the queue.
// ----------------------------------------------------------------------------
module spq_datapath
    import spq_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_operation,
    input  wire logic [15:0] i_person_id,
    input  wire logic [7:0]  i_job_code,
    input  wire logic [7:0]  i_age_years,
    input  wire t_cmd        i_cmd,
    output t_sts             o_sts,
    input  wire logic        i_out_ready,
    output logic             o_out_valid,
    output logic [1:0]       o_status,
    output logic [15:0]      o_served_id,
    output logic             o_head_valid,
    output logic [15:0]      o_head_id,
    output logic [2:0]       o_head_priority,
    output logic [6:0]       o_waiting_count
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE = CW'(1);

    t_entry r_mem [CAPACITY];

    // Captured input word.
    logic        r_op;
    logic [15:0] r_id;
    logic [2:0]  r_score;

    logic [CW-1:0] r_signup;
    logic [CW-1:0] r_waiting;

    logic          r_head_valid;
    logic [IW-1:0] r_head_idx;
    logic [15:0]   r_head_id;
    logic [2:0]    r_head_score;

    logic [CW-1:0] r_scan_addr;
    logic          r_rd_valid;
    logic [IW-1:0] r_rd_idx;
    t_entry        r_rd_data;

    logic          r_best_valid;
    logic [IW-1:0] r_best_idx;
    logic [15:0]   r_best_id;
    logic [2:0]    r_best_score;

    logic [1:0]  r_res_status;
    logic [15:0] r_res_served;

    logic [1:0]  r_out_status;
    logic [15:0] r_out_served;
    logic        r_out_head_valid;
    logic [15:0] r_out_head_id;
    logic [2:0]  r_out_head_score;
    logic [CW-1:0] r_out_waiting;
    logic        r_out_valid;

    logic   full;
    logic   we;
    logic [IW-1:0] waddr;
    t_entry wdata;
    logic   rd_en;
    logic   better;

    assign full  = (r_signup == CAP);
    assign rd_en = i_cmd.scan_step && (r_scan_addr != r_signup);
    assign better = r_rd_valid && r_rd_data.waiting
                    && (!r_best_valid || (r_rd_data.score > r_best_score));

    always_comb begin
        we    = 1'b0;
        waddr = r_signup[IW-1:0];
        wdata = '{waiting: 1'b1, score: r_score, id: r_id};
        if (i_cmd.do_add && !full) begin
            we = 1'b1;
        end else if (i_cmd.do_clr) begin
            we    = 1'b1;
            waddr = r_head_idx;
            wdata = '{waiting: 1'b0, score: r_head_score, id: r_head_id};
        end
    end

    // Store: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_scan_addr[IW-1:0]];
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op         <= i_operation;
            r_id         <= i_person_id;
            r_score      <= score_of(i_job_code, i_age_years);
            r_res_status <= ST_OK;
            r_res_served <= '0;
        end
        if (i_cmd.set_empty) begin
            r_res_status <= ST_EMPTY;
        end
        if (i_cmd.do_add && full) begin
            r_res_status <= ST_FULL;
        end
        if (i_cmd.do_clr) begin
            r_res_served <= r_head_id;
            r_scan_addr  <= '0;
        end
        if (rd_en) begin
            r_scan_addr <= r_scan_addr + ONE;
            r_rd_idx    <= r_scan_addr[IW-1:0];
        end
        if (i_cmd.scan_step && better) begin
            r_best_idx   <= r_rd_idx;
            r_best_id    <= r_rd_data.id;
            r_best_score <= r_rd_data.score;
        end
        if (i_cmd.do_add && !full && (!r_head_valid || (r_score > r_head_score))) begin
            r_head_idx   <= r_signup[IW-1:0];
            r_head_id    <= r_id;
            r_head_score <= r_score;
        end
        if (i_cmd.scan_finish) begin
            r_head_idx   <= r_best_idx;
            r_head_id    <= r_best_id;
            r_head_score <= r_best_score;
        end
        if (i_cmd.load_out) begin
            r_out_status     <= r_res_status;
            r_out_served     <= r_res_served;
            r_out_head_valid <= r_head_valid;
            r_out_head_id    <= r_head_valid ? r_head_id : 16'd0;
            r_out_head_score <= r_head_valid ? r_head_score : 3'd0;
            r_out_waiting    <= r_waiting;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_signup     <= '0;
            r_waiting    <= '0;
            r_head_valid <= 1'b0;
            r_rd_valid   <= 1'b0;
            r_best_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.do_add && !full) begin
                r_signup     <= r_signup + ONE;
                r_waiting    <= r_waiting + ONE;
                r_head_valid <= 1'b1;
            end
            if (i_cmd.do_clr) begin
                r_waiting    <= r_waiting - ONE;
                r_rd_valid   <= 1'b0;
                r_best_valid <= 1'b0;
            end
            if (i_cmd.scan_step) begin
                r_rd_valid <= rd_en;
                if (better) begin
                    r_best_valid <= 1'b1;
                end
            end
            if (i_cmd.scan_finish) begin
                r_head_valid <= r_best_valid;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.op_serve   = (r_op == OP_SERVE);
    assign o_sts.head_valid = r_head_valid;
    assign o_sts.scan_done  = (r_scan_addr == r_signup) && !r_rd_valid;
    assign o_sts.out_busy   = r_out_valid && !i_out_ready;

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_served_id     = r_out_served;
    assign o_head_valid    = r_out_head_valid;
    assign o_head_id       = r_out_head_id;
    assign o_head_priority = r_out_head_score;
    assign o_waiting_count = 7'(r_out_waiting);

endmodule
`default_nettype wire

FILE: test/scored_priority_queue_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scored_priority_queue_tb
// Self-checking bench for the scored priority queue. A short directed table
// covers the scoring thresholds, every job letter, tie breaking, serving down
// to an empty queue and the empty-queue error. Random traffic follows, fills
// the sign-up store to its limit, provokes rejected adds and drains the queue.
// Every result word is checked against the value typed into its row or a
// behavioral model of the queue kept in this bench, under random idling on both channels.
// ----------------------------------------------------------------------------
module scored_priority_queue_tb;
    import spq_pkg::*;

    localparam int CAPACITY     = 64;
    localparam int RANDOM_WORDS = 750;
    // Slowest word is a serve over a full store, plus the longest receiver
    // stall and the longest sender gap, taken about four times over for every
    // word of the run.
    localparam int CYCLE_LIMIT  = 800000;

    // One result word as the block reports it.
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] served_id;
        logic        head_valid;
        logic [15:0] head_id;
        logic [2:0]  head_priority;
        logic [6:0]  waiting_count;
    } report_t;

    // One row of the directed table. When known is set, the expected result
    // is the one typed into the row; otherwise the queue model supplies it.
    typedef struct {
        logic        op;
        logic [15:0] id;
        logic [7:0]  job;
        logic [7:0]  age;
        bit          known;
        report_t     rep;
    } stim_row_t;

    // Every input starts at a known value.
    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_in_valid   = 1'b0;
    logic        i_operation  = OP_ADD;
    logic [15:0] i_person_id  = '0;
    logic [7:0]  i_job_code   = '0;
    logic [7:0]  i_age_years  = '0;
    logic        i_out_ready  = 1'b0;

    logic        o_in_ready;
    logic        o_out_valid;
    logic [1:0]  o_status;
    logic [15:0] o_served_id;
    logic        o_head_valid;
    logic [15:0] o_head_id;
    logic [2:0]  o_head_priority;
    logic [6:0]  o_waiting_count;

    scored_priority_queue #(
        .CAPACITY(CAPACITY)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_operation    (i_operation),
        .i_person_id    (i_person_id),
        .i_job_code     (i_job_code),
        .i_age_years    (i_age_years),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_served_id    (o_served_id),
        .o_head_valid   (o_head_valid),
        .o_head_id      (o_head_id),
        .o_head_priority(o_head_priority),
        .o_waiting_count(o_waiting_count)
    );

    // Period of four time units.
    always #2 i_clk = ~i_clk;

    int cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // While bits 12 and 11 of the cycle count are both set, neither side idles,
    // so back-to-back traffic is seen as well as gappy traffic.
    wire calm = (cycle_count[12:11] == 2'b11);

    // ------------------------------------------------------------------------
    // Queue model. The sign-up ledger mirrors the block's store: slots fill in
    // order, served people keep their slot and only lose their waiting mark.
    // ------------------------------------------------------------------------
    logic [15:0] ledger_ids     [CAPACITY];
    logic [2:0]  ledger_scores  [CAPACITY];
    logic        ledger_waiting [CAPACITY];
    int          signups_used  = 0;
    int          still_waiting = 0;

    int adds_taken   = 0;
    int adds_refused = 0;
    int serves_done  = 0;
    int serves_empty = 0;
    int most_waiting = 0;

    // Results still owed by the block, oldest first.
    report_t pending_reports[$];
    report_t oldest_report;
    int      mismatch_count = 0;
    int      results_seen   = 0;

    initial begin
        for (int k = 0; k < CAPACITY; k++) begin
            ledger_waiting[k] = 1'b0;
        end
    end

    // Job points plus age points.
    function automatic logic [2:0] rate_person(input logic [7:0] job, input logic [7:0] age);
        logic [2:0] pts;
        case (job)
            JOB_M:   pts = 3'd3;
            JOB_S:   pts = 3'd2;
            JOB_O:   pts = 3'd1;
            default: pts = 3'd0;
        endcase
        if (age >= AGE_SENIOR) begin
            pts = pts + 3'd4;
        end else if (age >= AGE_MIDDLE) begin
            pts = pts + 3'd3;
        end else if (age >= AGE_ADULT) begin
            pts = pts + 3'd2;
        end else begin
            pts = pts + 3'd1;
        end
        return pts;
    endfunction

    // Slot of the highest score among waiting people. Only a strictly higher
    // score displaces the current best, so the earliest sign-up wins a tie.
    // Returns -1 when nobody waits.
    function automatic int best_waiting();
        int best;
        best = -1;
        for (int k = 0; k < signups_used; k++) begin
            if (ledger_waiting[k] && (best < 0 || ledger_scores[k] > ledger_scores[best])) begin
                best = k;
            end
        end
        return best;
    endfunction

    // Apply one accepted word to the model and work out the result it causes.
    task automatic apply_word(input logic op, input logic [15:0] id, input logic [7:0] job,
                              input logic [7:0] age, output report_t rep);
        int slot;
        rep = '0;
        if (op == OP_ADD) begin
            if (signups_used >= CAPACITY) begin
                // The store never frees a slot, so once full every add bounces.
                rep.status = ST_FULL;
                adds_refused++;
            end else begin
                ledger_ids[signups_used]     = id;
                ledger_scores[signups_used]  = rate_person(job, age);
                ledger_waiting[signups_used] = 1'b1;
                signups_used++;
                still_waiting++;
                adds_taken++;
            end
        end else begin
            slot = best_waiting();
            if (slot < 0) begin
                rep.status = ST_EMPTY;
                serves_empty++;
            end else begin
                rep.served_id        = ledger_ids[slot];
                ledger_waiting[slot] = 1'b0;
                still_waiting--;
                serves_done++;
            end
        end
        slot = best_waiting();
        if (slot >= 0) begin
            rep.head_valid    = 1'b1;
            rep.head_id       = ledger_ids[slot];
            rep.head_priority = ledger_scores[slot];
        end
        rep.waiting_count = still_waiting[6:0];
        if (still_waiting > most_waiting) begin
            most_waiting = still_waiting;
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: random backpressure and the checker.
    // ------------------------------------------------------------------------
    int ready_hold = 0;
    int ready_roll;

    always @(posedge i_clk) begin
        ready_roll = $urandom_range(0, 99);
        if (!i_rst_n || calm) begin
            i_out_ready <= 1'b1;
        end else if (ready_hold > 0) begin
            ready_hold--;
            i_out_ready <= 1'b0;
        end else if (ready_roll < 70) begin
            i_out_ready <= 1'b1;
        end else if (ready_roll < 95) begin
            ready_hold = $urandom_range(0, 3);
            i_out_ready <= 1'b0;
        end else begin
            ready_hold = $urandom_range(20, 80);
            i_out_ready <= 1'b0;
        end
    end

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            mismatch_count++;
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endfunction

    // Outputs and the ready are read as they stood just before the edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (pending_reports.size() == 0) begin
                mismatch_count++;
                $display("%0t: result word with nothing expected, status %0h served %0h",
                         $time, o_status, o_served_id);
            end else begin
                oldest_report = pending_reports.pop_front();
                check_field("status",        oldest_report.status,        o_status);
                check_field("served_id",     oldest_report.served_id,     o_served_id);
                check_field("head_valid",    oldest_report.head_valid,    o_head_valid);
                check_field("head_id",       oldest_report.head_id,       o_head_id);
                check_field("head_priority", oldest_report.head_priority, o_head_priority);
                check_field("waiting_count", oldest_report.waiting_count, o_waiting_count);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Input side.
    // ------------------------------------------------------------------------

    // Present one word and hold it until the block takes it. The call starts
    // in the time step of a rising edge, so the payload lands on that edge.
    task automatic send_word(input logic op, input logic [15:0] id, input logic [7:0] job,
                             input logic [7:0] age, input bit known, input report_t typed_rep);
        report_t predicted;
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_person_id <= id;
        i_job_code  <= job;
        i_age_years <= age;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        apply_word(op, id, job, age, predicted);
        pending_reports.push_back(known ? typed_rep : predicted);
    endtask

    // Valid is only lowered when a real gap follows, so back-to-back words
    // keep it high without a second assignment in the same step.
    task automatic idle_sender(input int cycles);
        if (cycles > 0) begin
            i_in_valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // Hold off the sender until every owed result has been taken.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_reports.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 70) begin
            return 0;
        end else if (roll < 95) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(20, 80);
    endfunction

    function automatic stim_row_t row(input logic op, input logic [15:0] id,
                                      input logic [7:0] job, input logic [7:0] age,
                                      input bit known = 1'b0, input report_t rep = '0);
        stim_row_t r;
        r.op    = op;
        r.id    = id;
        r.job   = job;
        r.age   = age;
        r.known = known;
        r.rep   = rep;
        return r;
    endfunction

    stim_row_t directed[$];

    // Watchdog: a hang anywhere ends the run as a failure.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
        end
        $display("%0t: timeout after %0d cycles, %0d results still owed",
                 $time, cycle_count, pending_reports.size());
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        int          n;
        int          serve_pct;
        logic        op;
        logic [15:0] id;
        logic [7:0]  job;
        logic [7:0]  age;

        // A serve before anyone signs up is the empty-queue error; its
        // payload is all ones to show that a serve ignores it.
        directed.push_back(row(OP_SERVE, 16'hFFFF, 8'hFF, 8'hFF, 1'b1,
                               report_t'{ST_EMPTY, 16'h0, 1'b0, 16'h0, 3'd0, 7'd0}));
        // Highest id, top job and top age: score 7 at once.
        directed.push_back(row(OP_ADD, 16'hFFFF, JOB_M, 8'd255, 1'b1,
                               report_t'{ST_OK, 16'h0, 1'b1, 16'hFFFF, 3'd7, 7'd1}));
        // Id zero, no job, age zero: score 1, the head does not move.
        directed.push_back(row(OP_ADD, 16'h0000, 8'h00, 8'd0, 1'b1,
                               report_t'{ST_OK, 16'h0, 1'b1, 16'hFFFF, 3'd7, 7'd2}));
        // Each age band on both sides of its threshold, with every job letter
        // and a couple of bytes that only look like one.
        directed.push_back(row(OP_ADD, 16'h1111, JOB_S, 8'd59));
        directed.push_back(row(OP_ADD, 16'h2222, JOB_O, 8'd40));
        directed.push_back(row(OP_ADD, 16'h3333, JOB_O, 8'd39));
        directed.push_back(row(OP_ADD, 16'h4444, JOB_M, 8'd20));
        directed.push_back(row(OP_ADD, 16'h5555, JOB_S, 8'd19));
        directed.push_back(row(OP_ADD, 16'h6666, 8'hFF, 8'd60));
        directed.push_back(row(OP_ADD, 16'h7777, JOB_M, 8'd19));
        directed.push_back(row(OP_ADD, 16'h8888, 8'h6D, 8'd60));
        // Serve everyone: several score ties must go to the earliest sign-up,
        // and the last one served has id zero.
        for (int k = 0; k < 10; k++) begin
            directed.push_back(row(OP_SERVE, 16'($urandom), 8'($urandom), 8'($urandom)));
        end
        directed.push_back(row(OP_SERVE, 16'h0000, 8'h00, 8'h00, 1'b1,
                               report_t'{ST_EMPTY, 16'h0, 1'b0, 16'h0, 3'd0, 7'd0}));
        directed.push_back(row(OP_ADD, 16'h8000, JOB_M, 8'd60));
        directed.push_back(row(OP_ADD, 16'h0001, 8'h4C, 8'd255));

        // Reset is held low once, at the start of the run.
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k]) begin
            send_word(directed[k].op, directed[k].id, directed[k].job, directed[k].age,
                      directed[k].known, directed[k].rep);
            idle_sender(pick_gap());
        end
        drain_results();

        // Random traffic. The share of serves changes every sixteen words so
        // the queue both builds up and runs dry while the store fills. Once
        // the store is full, most words are serves that drain the queue and
        // the rest are adds that must bounce.
        serve_pct = 40;
        for (n = 0; n < RANDOM_WORDS; n++) begin
            if (n % 16 == 0) begin
                serve_pct = $urandom_range(15, 60);
            end
            if (n == RANDOM_WORDS / 2) begin
                drain_results();
            end
            id = 16'($urandom);
            case ($urandom_range(0, 4))
                0:       job = JOB_M;
                1:       job = JOB_S;
                2:       job = JOB_O;
                default: job = 8'($urandom);
            endcase
            case ($urandom_range(0, 9))
                0:       age = 8'd0;
                1:       age = 8'd19;
                2:       age = 8'd20;
                3:       age = 8'd39;
                4:       age = 8'd40;
                5:       age = 8'd59;
                6:       age = 8'd60;
                7:       age = 8'd255;
                default: age = 8'($urandom);
            endcase
            if (signups_used < CAPACITY) begin
                op = ($urandom_range(0, 99) < serve_pct) ? OP_SERVE : OP_ADD;
            end else begin
                op = ($urandom_range(0, 99) < 75) ? OP_SERVE : OP_ADD;
            end
            send_word(op, id, job, age, 1'b0, '0);
            idle_sender(pick_gap());
        end

        // Wait for the last results, then long enough for a full-store serve
        // to show any stray word.
        drain_results();
        repeat (CAPACITY + 20) @(posedge i_clk);

        $display("covered %0d signups (%0d refused on a full store), %0d serves, %0d on empty",
                 adds_taken, adds_refused, serves_done, serves_empty);
        $display("checked %0d result words, at most %0d people waiting, %0d cycles",
                 results_seen, most_waiting, cycle_count);
        if (mismatch_count == 0 && pending_reports.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
`default_nettype wire

FILE: filelist.f
rtl/core/spq_pkg.sv
rtl/core/spq_ctrl.sv
rtl/core/spq_datapath.sv
rtl/core/scored_priority_queue.sv
test/scored_priority_queue_tb.sv
